### rtl/core/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define PCDR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcdr assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define PCDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcdr assertion failed");

`endif

### rtl/core/pcdr_pkg.sv
// Shared types and constants of the pointer click/drag recogniser.
// No dependencies; imported by controller, datapath, top level and checker.
package pcdr_pkg;

    localparam int BUTTONS = 8;
    localparam int BTN_W   = $clog2(BUTTONS);
    localparam int IN_DW   = 120;
    localparam int OUT_DW  = 112;

    // input modes
    localparam logic [2:0] MODE_PRESS   = 3'd0;
    localparam logic [2:0] MODE_RELEASE = 3'd1;
    localparam logic [2:0] MODE_MOVE    = 3'd2;
    localparam logic [2:0] MODE_WHEEL   = 3'd3;
    localparam logic [2:0] MODE_ENTER   = 3'd4;
    localparam logic [2:0] MODE_LEAVE   = 3'd5;
    localparam logic [2:0] MODE_FRAME   = 3'd6;

    // result kinds
    localparam logic [2:0] KIND_STATUS = 3'd0;
    localparam logic [2:0] KIND_CLICK  = 3'd1;
    localparam logic [2:0] KIND_MOVE   = 3'd2;
    localparam logic [2:0] KIND_WHEEL  = 3'd3;
    localparam logic [2:0] KIND_DRAG   = 3'd4;

    // register indexes
    localparam logic [2:0] REG_ENABLE    = 3'd0;
    localparam logic [2:0] REG_DCLICK_MS = 3'd1;
    localparam logic [2:0] REG_DRAG_THR  = 3'd2;
    localparam logic [2:0] REG_SENS      = 3'd3;
    localparam logic [2:0] REG_FILT_EN   = 3'd4;
    localparam logic [2:0] REG_MIN_MOVE  = 3'd5;

    // operand selection of the distance unit
    typedef enum logic [1:0] {
        DS_PRESS = 2'd0,   // event position vs last click place
        DS_FILT  = 2'd1,   // event position vs cursor
        DS_DRAG  = 2'd2    // new cursor vs last click place
    } t_dsel;

    typedef struct packed {
        logic             latch_in;
        logic             dist_go;
        t_dsel            dsel;
        logic [BTN_W-1:0] sel;
        logic             press_upd;
        logic             rel_upd;
        logic             enter_upd;
        logic             frame_clr;
        logic             filt_upd;
        logic             drag_set;
        logic             out_load;
        logic [2:0]       out_kind;
    } t_cmd;

    typedef struct packed {
        logic             enable;
        logic [2:0]       mode;
        logic             btn_ok;
        logic [BTN_W-1:0] btn;
        logic             held_sel;
        logic             drag_sel;
        logic             le_thr;
        logic             out_free;
    } t_sts;

endpackage

### rtl/core/pointer_click_drag_recognizer_top.sv
// Top level of the pointer click/drag recogniser: ports, controller and datapath.
// Depends on pcdr_pkg, pcdr_ctrl and pcdr_datapath.
//
// Takes one pointer event per transaction on the slave stream and returns one or
// more result transactions on the master stream, the final one marked by tlast.
// Events are handled one at a time: a status, wheel or release event goes from
// dispatch to its result state, a press through dispatch, press update and click,
// and a move through dispatch and filter, then a scan of every button with a
// compare step for each held one: the drag test walks the buttons in order
// through the single shared squared-distance unit (squares registered in the
// scan step, compared in the compare step). Each result needs the output
// register free; back-pressure on the master side holds the sequence until it
// is. A finished result may wait in the output register while the next event is
// accepted. Configuration writes are always accepted and take effect on the next
// cycle, the squared thresholds registered from them in turn; write only while
// idle. No clearing pass is needed after reset.
module pointer_click_drag_recognizer_top import pcdr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // button[3:0] pos_x[19:4] pos_y[35:20] move_dx[51:36] move_dy[67:52]
    // wheel_amount[83:68] time_ms[115:84], zero pad above
    input  logic [IN_DW-1:0]  s_axis_tdata,
    // mode[2:0]
    input  logic [2:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // which_button[2:0] click_count[6:3] out_x[22:7] out_y[38:23] aux_x[54:39]
    // aux_y[70:55] wheel_out[86:71] pressed_mask[94:87] just_pressed_mask[102:95]
    // just_released_mask[110:103], zero pad above
    output logic [OUT_DW-1:0] m_axis_tdata,
    // kind[2:0]
    output logic [2:0]        m_axis_tuser,
    output logic              m_axis_tlast,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // registers are plain flops, so a write never has to wait
    assign o_cfg_ready = 1'b1;

    pcdr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pcdr_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_valid   (m_axis_tvalid),
        .o_m_data    (m_axis_tdata),
        .o_m_user    (m_axis_tuser),
        .o_m_last    (m_axis_tlast),
        .i_m_ready   (m_axis_tready)
    );

endmodule

### rtl/core/pcdr_datapath.sv
// Datapath: config registers, button state, distance unit, scaler and output register.
// Depends on pcdr_pkg; driven by pcdr_ctrl.
module pcdr_datapath import pcdr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [IN_DW-1:0]  i_in_data,
    input  logic [2:0]        i_in_user,
    input  logic              i_cfg_valid,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    output logic              o_m_valid,
    output logic [OUT_DW-1:0] o_m_data,
    output logic [2:0]        o_m_user,
    output logic              o_m_last,
    input  logic              i_m_ready
);

    function automatic logic signed [15:0] sat_scale(input logic signed [24:0] p);
        logic signed [20:0] q;
        q = 21'(p >>> 4);
        if (q > 21'sd32767)       return 16'sh7fff;
        else if (q < -21'sd32768) return 16'sh8000;
        else                      return q[15:0];
    endfunction

    // config
    logic        r_enable, r_filt_en;
    logic [15:0] r_dclick_ms;
    logic [14:0] r_drag_thr, r_min_move;
    logic [7:0]  r_sens;
    logic [29:0] r_thr2, r_min2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b1;
            r_dclick_ms <= 16'd500;
            r_drag_thr  <= 15'd80;
            r_sens      <= 8'd16;
            r_filt_en   <= 1'b0;
            r_min_move  <= 15'd16;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ENABLE:    r_enable    <= i_cfg_data[0];
                REG_DCLICK_MS: r_dclick_ms <= i_cfg_data;
                REG_DRAG_THR:  r_drag_thr  <= i_cfg_data[14:0];
                REG_SENS:      r_sens      <= i_cfg_data[7:0];
                REG_FILT_EN:   r_filt_en   <= i_cfg_data[0];
                REG_MIN_MOVE:  r_min_move  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr2 <= 30'(r_drag_thr) * 30'(r_drag_thr);
        r_min2 <= 30'(r_min_move) * 30'(r_min_move);
    end

    // latched event
    logic [2:0]         r_mode;
    logic [3:0]         r_btn;
    logic signed [15:0] r_px, r_py, r_mdx, r_mdy, r_wamt;
    logic [31:0]        r_now;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_mode <= i_in_user;
            r_btn  <= i_in_data[3:0];
            r_px   <= i_in_data[19:4];
            r_py   <= i_in_data[35:20];
            r_mdx  <= i_in_data[51:36];
            r_mdy  <= i_in_data[67:52];
            r_wamt <= i_in_data[83:68];
            r_now  <= i_in_data[115:84];
        end
    end

    // gain products, registered ahead of the shift and saturation
    logic signed [24:0] r_scx, r_scy, r_scw;
    always_ff @(posedge i_clk) begin
        r_scx <= r_mdx  * $signed({1'b0, r_sens});
        r_scy <= r_mdy  * $signed({1'b0, r_sens});
        r_scw <= r_wamt * $signed({1'b0, r_sens});
    end

    // button state
    logic [BUTTONS-1:0] r_held, r_jp, r_jr, r_drag, r_seen;
    logic [3:0]         r_clicks  [BUTTONS];
    logic [31:0]        r_stamp   [BUTTONS];
    logic signed [15:0] r_place_x [BUTTONS];
    logic signed [15:0] r_place_y [BUTTONS];
    logic signed [15:0] r_cur_x, r_cur_y;

    logic signed [15:0] pl_x, pl_y;
    assign pl_x = r_place_x[i_cmd.sel];
    assign pl_y = r_place_y[i_cmd.sel];

    // distance unit: squares registered, sum and compare next cycle
    logic signed [15:0] a_x, a_y, b_x, b_y;
    logic signed [16:0] dx, dy;
    logic signed [33:0] r_sqx, r_sqy;
    logic               r_gap_ok;
    logic [34:0]        dsum;
    logic               le_thr, lt_min;

    assign a_x = (i_cmd.dsel == DS_DRAG) ? r_cur_x : r_px;
    assign a_y = (i_cmd.dsel == DS_DRAG) ? r_cur_y : r_py;
    assign b_x = (i_cmd.dsel == DS_FILT) ? r_cur_x : pl_x;
    assign b_y = (i_cmd.dsel == DS_FILT) ? r_cur_y : pl_y;
    assign dx  = 17'(a_x) - 17'(b_x);
    assign dy  = 17'(a_y) - 17'(b_y);

    always_ff @(posedge i_clk) begin
        if (i_cmd.dist_go) begin
            r_sqx    <= dx * dx;
            r_sqy    <= dy * dy;
            r_gap_ok <= (r_now - r_stamp[i_cmd.sel]) <= {16'd0, r_dclick_ms};
        end
    end

    assign dsum   = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign le_thr = dsum <= {5'd0, r_thr2};
    assign lt_min = dsum <  {5'd0, r_min2};

    // halved step towards the event position
    logic signed [16:0] hdx, hdy;
    logic signed [15:0] fx, fy;
    assign hdx = (17'(r_px) - 17'(r_cur_x)) >>> 1;
    assign hdy = (17'(r_py) - 17'(r_cur_y)) >>> 1;
    assign fx  = r_cur_x + hdx[15:0];
    assign fy  = r_cur_y + hdy[15:0];

    logic again;
    assign again = r_seen[i_cmd.sel] & r_gap_ok & le_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_jp    <= '0;
            r_jr    <= '0;
            r_drag  <= '0;
            r_seen  <= '0;
            r_cur_x <= '0;
            r_cur_y <= '0;
            for (int i = 0; i < BUTTONS; i++) begin
                r_clicks[i]  <= '0;
                r_stamp[i]   <= '0;
                r_place_x[i] <= '0;
                r_place_y[i] <= '0;
            end
        end else begin
            if (i_cmd.press_upd) begin
                r_held[i_cmd.sel]    <= 1'b1;
                r_jp[i_cmd.sel]      <= 1'b1;
                r_seen[i_cmd.sel]    <= 1'b1;
                r_clicks[i_cmd.sel]  <= !again ? 4'd1 :
                    (r_clicks[i_cmd.sel] == 4'd15) ? 4'd15 : r_clicks[i_cmd.sel] + 4'd1;
                r_stamp[i_cmd.sel]   <= r_now;
                r_place_x[i_cmd.sel] <= r_px;
                r_place_y[i_cmd.sel] <= r_py;
            end
            if (i_cmd.rel_upd) begin
                r_held[i_cmd.sel] <= 1'b0;
                r_jr[i_cmd.sel]   <= 1'b1;
                r_drag[i_cmd.sel] <= 1'b0;
            end
            if (i_cmd.frame_clr) begin
                r_jp <= '0;
                r_jr <= '0;
            end
            if (i_cmd.enter_upd) begin
                r_cur_x <= r_px;
                r_cur_y <= r_py;
            end
            if (i_cmd.filt_upd) begin
                r_cur_x <= (r_filt_en && lt_min) ? fx : r_px;
                r_cur_y <= (r_filt_en && lt_min) ? fy : r_py;
            end
            if (i_cmd.drag_set)
                r_drag[i_cmd.sel] <= 1'b1;
        end
    end

    // output register
    logic               r_ovalid, r_olast;
    logic [2:0]         r_okind, r_obtn;
    logic [3:0]         r_ocnt;
    logic signed [15:0] r_ox, r_oy, r_ax, r_ay, r_ow;
    logic [7:0]         r_opm, r_ojp, r_ojr;
    logic               out_free;

    assign out_free = !r_ovalid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_ovalid <= 1'b0;
        else if (i_cmd.out_load)
            r_ovalid <= 1'b1;
        else if (i_m_ready)
            r_ovalid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_okind <= i_cmd.out_kind;
            r_obtn  <= 3'd0;
            r_ocnt  <= 4'd0;
            r_ox    <= r_cur_x;
            r_oy    <= r_cur_y;
            r_ax    <= '0;
            r_ay    <= '0;
            r_ow    <= '0;
            r_olast <= 1'b1;
            r_opm   <= 8'(r_held);
            r_ojp   <= 8'(r_jp);
            r_ojr   <= 8'(r_jr);
            case (i_cmd.out_kind)
                KIND_CLICK: begin
                    r_obtn <= 3'(i_cmd.sel);
                    r_ocnt <= r_clicks[i_cmd.sel];
                    r_ox   <= r_px;
                    r_oy   <= r_py;
                end
                KIND_DRAG: begin
                    r_obtn  <= 3'(i_cmd.sel);
                    r_ax    <= pl_x;
                    r_ay    <= pl_y;
                    r_olast <= 1'b0;
                end
                KIND_MOVE: begin
                    r_ax <= sat_scale(r_scx);
                    r_ay <= sat_scale(r_scy);
                end
                KIND_WHEEL: begin
                    r_ox <= r_px;
                    r_oy <= r_py;
                    r_ow <= sat_scale(r_scw);
                end
                default: ;
            endcase
        end
    end

    assign o_m_valid = r_ovalid;
    assign o_m_user  = r_okind;
    assign o_m_last  = r_olast;
    assign o_m_data  = {1'b0, r_ojr, r_ojp, r_opm, r_ow, r_ay, r_ax, r_oy, r_ox,
                        r_ocnt, r_obtn};

    always_comb begin
        o_sts          = '0;
        o_sts.enable   = r_enable;
        o_sts.mode     = r_mode;
        o_sts.btn_ok   = r_btn < 4'(BUTTONS);
        o_sts.btn      = r_btn[BTN_W-1:0];
        o_sts.held_sel = r_held[i_cmd.sel];
        o_sts.drag_sel = r_drag[i_cmd.sel];
        o_sts.le_thr   = le_thr;
        o_sts.out_free = out_free;
    end

endmodule

### rtl/core/pcdr_ctrl.sv
// Controller: one-hot sequencer that steps the datapath through one event.
// Depends on pcdr_pkg; drives pcdr_datapath through t_cmd.
module pcdr_ctrl import pcdr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DISP   = 10'b0000000010,
        S_PRESS  = 10'b0000000100,
        S_CLICK  = 10'b0000001000,
        S_FILT   = 10'b0000010000,
        S_SCAN   = 10'b0000100000,
        S_SCMP   = 10'b0001000000,
        S_MOVE   = 10'b0010000000,
        S_WHEEL  = 10'b0100000000,
        S_STATUS = 10'b1000000000
    } t_state;

    t_state           r_state, n_state;
    logic [BTN_W-1:0] r_idx, n_idx;
    logic             idx_last, active;

    assign idx_last = (r_idx == BTN_W'(BUTTONS - 1));
    assign active   = i_sts.drag_sel | !i_sts.le_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_cmd      = '0;
        o_cmd.dsel = DS_PRESS;
        o_cmd.sel  = r_idx;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.latch_in = i_in_valid;
                if (i_in_valid) n_state = S_DISP;
            end
            S_DISP: begin
                o_cmd.sel = i_sts.btn;
                n_state   = S_STATUS;
                if (i_sts.enable) begin
                    case (i_sts.mode)
                        MODE_PRESS: begin
                            if (i_sts.btn_ok) begin
                                o_cmd.dist_go = 1'b1;
                                n_state       = S_PRESS;
                            end
                        end
                        MODE_RELEASE: o_cmd.rel_upd = i_sts.btn_ok;
                        MODE_MOVE: begin
                            o_cmd.dist_go = 1'b1;
                            o_cmd.dsel    = DS_FILT;
                            n_state       = S_FILT;
                        end
                        MODE_WHEEL: n_state = S_WHEEL;
                        MODE_ENTER: o_cmd.enter_upd = 1'b1;
                        MODE_FRAME: o_cmd.frame_clr = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_PRESS: begin
                o_cmd.sel       = i_sts.btn;
                o_cmd.press_upd = 1'b1;
                n_state         = S_CLICK;
            end
            S_CLICK: begin
                o_cmd.sel      = i_sts.btn;
                o_cmd.out_kind = KIND_CLICK;
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_FILT: begin
                o_cmd.dsel     = DS_FILT;
                o_cmd.filt_upd = 1'b1;
                n_idx          = '0;
                n_state        = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.dsel = DS_DRAG;
                if (i_sts.held_sel) begin
                    o_cmd.dist_go = 1'b1;
                    n_state       = S_SCMP;
                end else if (idx_last) begin
                    n_state = S_MOVE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SCMP: begin
                o_cmd.dsel     = DS_DRAG;
                o_cmd.out_kind = KIND_DRAG;
                if (active && i_sts.out_free) begin
                    o_cmd.drag_set = 1'b1;
                    o_cmd.out_load = 1'b1;
                end
                if (!active || i_sts.out_free) begin
                    if (idx_last) begin
                        n_state = S_MOVE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_MOVE, S_WHEEL, S_STATUS: begin
                o_cmd.out_kind = (r_state == S_MOVE)  ? KIND_MOVE :
                                 (r_state == S_WHEEL) ? KIND_WHEEL : KIND_STATUS;
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### rtl/core/pcdr_checker.sv
// Port-level checker of the pointer click/drag recogniser, bound to the top level.
// Depends on pcdr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pcdr_checker import pcdr_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [IN_DW-1:0]  s_axis_tdata,
    input logic [2:0]        s_axis_tuser,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_DW-1:0] m_axis_tdata,
    input logic [2:0]        m_axis_tuser,
    input logic              m_axis_tlast,
    input logic              i_cfg_valid,
    input logic              o_cfg_ready,
    input logic [2:0]        i_cfg_index,
    input logic [15:0]       i_cfg_data
);

    // one event at a time: no new transaction straight after an accepted one
    `PCDR_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // drag results never close an event
    `PCDR_ASSERT_SAME(a_drag_not_last, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == KIND_DRAG), !m_axis_tlast)

    // every other result closes its event
    `PCDR_ASSERT_SAME(a_other_last, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != KIND_DRAG), m_axis_tlast)

    // stalled result is held
    `PCDR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind pointer_click_drag_recognizer_top pcdr_checker u_pcdr_checker (.*);

### tb/tb_top.sv
// Self-checking testbench for the pointer click/drag recogniser top level.
// Depends on pcdr_pkg and pointer_click_drag_recognizer_top; the expected
// results come from a behavioural copy of the block kept in this file.
`timescale 1ns / 1ps

module tb_top;
    import pcdr_pkg::*;

    // one pointer event as driven on the slave stream
    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  button;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] move_dx;
        logic [15:0] move_dy;
        logic [15:0] wheel_amount;
        logic [31:0] time_ms;
    } t_event;

    // one result transaction, user and data halves kept apart
    typedef struct packed {
        logic [2:0]        kind;
        logic              last;
        logic [OUT_DW-1:0] data;
    } t_result;

    localparam int CYCLE_LIMIT = 400000;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_DW-1:0]  s_axis_tdata;
    logic [2:0]        s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_DW-1:0] m_axis_tdata;
    logic [2:0]        m_axis_tuser;
    logic              m_axis_tlast;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [2:0]        i_cfg_index;
    logic [15:0]       i_cfg_data;

    pointer_click_drag_recognizer_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // ---------------------------------------------------------------------
    // Shadow copy of the recogniser: registers and per-button state
    // ---------------------------------------------------------------------
    logic        sh_enable;
    logic [15:0] sh_dclick_ms;
    logic [14:0] sh_drag_thr;
    logic [7:0]  sh_sens;
    logic        sh_filt_en;
    logic [14:0] sh_min_move;

    logic [BUTTONS-1:0] sh_held, sh_new_press, sh_new_rel, sh_dragging, sh_clicked;
    logic [3:0]         sh_clicks [BUTTONS];
    logic [31:0]        sh_stamp  [BUTTONS];
    logic signed [15:0] sh_place_x [BUTTONS];
    logic signed [15:0] sh_place_y [BUTTONS];
    logic signed [15:0] sh_cur_x, sh_cur_y;

    t_event  pending_events [$];   // filled by the stimulus, drained by the driver
    t_result expected_results [$];

    int  mismatches = 0;
    int  cycles = 0;
    bit  timed_out = 1'b0;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_sender;   // sender waits for every result before each transaction

    function automatic longint sq_dist(longint ax, longint ay, longint bx, longint by);
        return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
    endfunction

    // Q4.4 gain, floor division, saturated to 16 bits signed
    function automatic logic [15:0] apply_gain(logic signed [15:0] v);
        longint p, q;
        p = longint'(v) * longint'(sh_sens);
        q = p >>> 4;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    task automatic push_result(logic [2:0] kind, logic [2:0] btn, logic [3:0] cnt,
                               logic [15:0] ox, logic [15:0] oy, logic [15:0] ax,
                               logic [15:0] ay, logic [15:0] wh);
        t_result r;
        r.kind = kind;
        r.last = 1'b0;
        r.data = '0;
        r.data[110:0] = {8'h00, 8'h00, 8'h00, wh, ay, ax, oy, ox, cnt, btn};
        expected_results.push_back(r);
    endtask

    task automatic predict_event(t_event ev);
        logic signed [15:0] px, py, nx, ny;
        logic [2:0] b3;
        longint thr2, ddx, ddy;
        int first, n, i;
        px    = ev.pos_x;
        py    = ev.pos_y;
        b3    = ev.button[2:0];
        thr2  = longint'(sh_drag_thr) * longint'(sh_drag_thr);
        first = expected_results.size();
        if (sh_enable && ev.mode == MODE_PRESS && ev.button < BUTTONS) begin
            if (sh_clicked[b3] && (ev.time_ms - sh_stamp[b3]) <= {16'd0, sh_dclick_ms}
                && sq_dist(px, py, sh_place_x[b3], sh_place_y[b3]) <= thr2) begin
                if (sh_clicks[b3] != 4'd15) sh_clicks[b3] = sh_clicks[b3] + 4'd1;
            end else begin
                sh_clicks[b3] = 4'd1;
            end
            sh_held[b3]      = 1'b1;
            sh_new_press[b3] = 1'b1;
            sh_clicked[b3]   = 1'b1;
            sh_stamp[b3]     = ev.time_ms;
            sh_place_x[b3]   = px;
            sh_place_y[b3]   = py;
            push_result(KIND_CLICK, b3, sh_clicks[b3], px, py, 16'd0, 16'd0, 16'd0);
        end else if (sh_enable && ev.mode == MODE_RELEASE && ev.button < BUTTONS) begin
            sh_held[b3]     = 1'b0;
            sh_new_rel[b3]  = 1'b1;
            sh_dragging[b3] = 1'b0;
        end else if (sh_enable && ev.mode == MODE_MOVE) begin
            nx = px;
            ny = py;
            if (sh_filt_en) begin
                ddx = longint'(px) - longint'(sh_cur_x);
                ddy = longint'(py) - longint'(sh_cur_y);
                if (ddx * ddx + ddy * ddy
                    < longint'(sh_min_move) * longint'(sh_min_move)) begin
                    nx = 16'(longint'(sh_cur_x) + (ddx >>> 1));
                    ny = 16'(longint'(sh_cur_y) + (ddy >>> 1));
                end
            end
            sh_cur_x = nx;
            sh_cur_y = ny;
            for (i = 0; i < BUTTONS; i++) begin
                if (sh_held[i]) begin
                    if (!sh_dragging[i] && sq_dist(nx, ny, sh_place_x[i], sh_place_y[i]) > thr2)
                        sh_dragging[i] = 1'b1;
                    if (sh_dragging[i])
                        push_result(KIND_DRAG, 3'(i), 4'd0, nx, ny,
                                    sh_place_x[i], sh_place_y[i], 16'd0);
                end
            end
            push_result(KIND_MOVE, 3'd0, 4'd0, nx, ny, apply_gain(ev.move_dx),
                        apply_gain(ev.move_dy), 16'd0);
        end else if (sh_enable && ev.mode == MODE_WHEEL) begin
            push_result(KIND_WHEEL, 3'd0, 4'd0, px, py, 16'd0, 16'd0,
                        apply_gain(ev.wheel_amount));
        end else if (sh_enable && ev.mode == MODE_ENTER) begin
            sh_cur_x = px;
            sh_cur_y = py;
        end else if (sh_enable && ev.mode == MODE_FRAME) begin
            sh_new_press = '0;
            sh_new_rel   = '0;
        end
        if (expected_results.size() == first)
            push_result(KIND_STATUS, 3'd0, 4'd0, sh_cur_x, sh_cur_y, 16'd0, 16'd0, 16'd0);
        // masks are taken once the event has been applied
        n = expected_results.size();
        for (i = first; i < n; i++)
            expected_results[i].data[110:87] = {sh_new_rel, sh_new_press, sh_held};
        expected_results[n - 1].last = 1'b1;
    endtask

    // ---------------------------------------------------------------------
    // Clock, cycle limit
    // ---------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT && !timed_out) begin
            timed_out <= 1'b1;
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Driver: one event transaction at a time from the pending queue.
    // The expectation is formed when the transaction is accepted.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            sh_held = '0; sh_new_press = '0; sh_new_rel = '0; sh_dragging = '0;
            sh_clicked = '0; sh_cur_x = '0; sh_cur_y = '0;
            for (int k = 0; k < BUTTONS; k++) begin
                sh_clicks[k] = '0; sh_stamp[k] = '0; sh_place_x[k] = '0; sh_place_y[k] = '0;
            end
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_event(pending_events.pop_front());
            end
            if ((!s_axis_tvalid || s_axis_tready)) begin
                if (pending_events.size() > 0
                    && !(hold_sender && expected_results.size() > 0)
                    && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= pending_events[0].mode;
                    s_axis_tdata  <= {4'd0, pending_events[0].time_ms,
                                      pending_events[0].wheel_amount,
                                      pending_events[0].move_dy,
                                      pending_events[0].move_dx,
                                      pending_events[0].pos_y,
                                      pending_events[0].pos_x,
                                      pending_events[0].button};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: compare each result transaction with the oldest expectation
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("tb: unexpected result kind=%0d data=%h",
                                 m_axis_tuser, m_axis_tdata);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_axis_tuser !== exp_r.kind || m_axis_tlast !== exp_r.last
                        || m_axis_tdata !== exp_r.data) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("tb: mismatch exp kind=%0d last=%0d data=%h got kind=%0d last=%0d data=%h",
                                     exp_r.kind, exp_r.last, exp_r.data,
                                     m_axis_tuser, m_axis_tlast, m_axis_tdata);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    logic [31:0] clock_ms;   // running event time, mostly advanced by small steps

    function automatic t_event make_event(logic [2:0] mode, logic [3:0] btn,
                                          logic [15:0] x, logic [15:0] y);
        t_event ev;
        ev.mode         = mode;
        ev.button       = btn;
        ev.pos_x        = x;
        ev.pos_y        = y;
        ev.move_dx      = 16'($urandom);
        ev.move_dy      = 16'($urandom);
        ev.wheel_amount = 16'($urandom);
        ev.time_ms      = clock_ms;
        return ev;
    endfunction

    task automatic queue_event(t_event ev);
        pending_events.push_back(ev);
    endtask

    task automatic wait_drained();
        while (pending_events.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        // a release also leaves a status result expected, which the loop above waits for
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_ENABLE:    sh_enable    = val[0];
            REG_DCLICK_MS: sh_dclick_ms = val;
            REG_DRAG_THR:  sh_drag_thr  = val[14:0];
            REG_SENS:      sh_sens      = val[7:0];
            REG_FILT_EN:   sh_filt_en   = val[0];
            REG_MIN_MOVE:  sh_min_move  = val[14:0];
            default: ;
        endcase
    endtask

    // A gesture: clicks, drags and other events near a spot, usually then a release.
    task automatic queue_gesture();
        logic [15:0] bx, by;
        logic [3:0]  btn;
        int k, steps;
        bx  = 16'($urandom_range(400) - 200);
        by  = 16'($urandom_range(400) - 200);
        btn = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 8)) : 4'($urandom_range(7));
        steps = $urandom_range(5, 1);
        for (k = 0; k < steps; k++) begin
            clock_ms = clock_ms + $urandom_range(700);
            case ($urandom_range(9))
                0, 1, 2: queue_event(make_event(MODE_PRESS, btn,
                             16'(bx + $urandom_range(60) - 30),
                             16'(by + $urandom_range(60) - 30)));
                3, 4, 5: queue_event(make_event(MODE_MOVE, btn,
                             16'(bx + $urandom_range(300) - 150),
                             16'(by + $urandom_range(300) - 150)));
                6: queue_event(make_event(MODE_RELEASE, btn, bx, by));
                7: queue_event(make_event(MODE_WHEEL, btn, 16'($urandom), 16'($urandom)));
                8: queue_event(make_event(MODE_FRAME, btn, 16'($urandom), 16'($urandom)));
                default: queue_event(make_event(3'($urandom_range(7)), 4'($urandom),
                             16'($urandom), 16'($urandom)));
            endcase
        end
        if ($urandom_range(3) != 0) begin
            clock_ms = clock_ms + $urandom_range(300);
            queue_event(make_event(MODE_RELEASE, btn, bx, by));
        end
    endtask

    task automatic queue_random_phase(int count);
        int start;
        start = pending_events.size();
        while (pending_events.size() - start < count) begin
            if ($urandom_range(9) < 8) begin
                queue_gesture();
            end else begin
                // noise, including wild timestamps and full-range fields
                clock_ms = ($urandom_range(3) == 0) ? $urandom : clock_ms + $urandom_range(50);
                queue_event(make_event(3'($urandom_range(7)), 4'($urandom),
                                       16'($urandom), 16'($urandom)));
            end
        end
    endtask

    task automatic random_config();
        write_reg(REG_DCLICK_MS, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(800)));
        write_reg(REG_DRAG_THR,  ($urandom_range(3) == 0) ? 16'($urandom_range(32767))
                                                           : 16'($urandom_range(150)));
        write_reg(REG_SENS,      16'($urandom_range(255)));
        write_reg(REG_FILT_EN,   16'($urandom_range(1)));
        write_reg(REG_MIN_MOVE,  ($urandom_range(3) == 0) ? 16'($urandom_range(32767))
                                                           : 16'($urandom_range(200)));
    endtask

    // ---------------------------------------------------------------------
    // Sequence of the run
    // ---------------------------------------------------------------------
    initial begin
        int i;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        hold_sender   = 1'b0;
        send_idle_pct = 27;
        recv_idle_pct = 52;
        clock_ms      = 32'hFFFF_FF00;   // wraps during the directed part
        sh_enable = 1'b1; sh_dclick_ms = 16'd500; sh_drag_thr = 15'd80;
        sh_sens = 8'd16; sh_filt_en = 1'b0; sh_min_move = 15'd16;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: first click, repeat with time wrap, invalid button,
        // drag past threshold, extreme fields, every mode, frame tick
        queue_event(make_event(MODE_PRESS, 4'd0, 16'd10, 16'd10));
        clock_ms = clock_ms + 300;
        queue_event(make_event(MODE_PRESS, 4'd0, 16'd20, 16'd20));
        queue_event(make_event(MODE_PRESS, 4'd15, 16'h7FFF, 16'h8000));
        queue_event(make_event(MODE_RELEASE, 4'd9, 16'h0, 16'h0));
        queue_event(make_event(MODE_PRESS, 4'd7, 16'h8000, 16'h7FFF));
        queue_event(make_event(MODE_MOVE, 4'd0, 16'h7FFF, 16'h7FFF));
        queue_event(make_event(MODE_MOVE, 4'd0, 16'h8000, 16'h8000));
        queue_event(make_event(MODE_WHEEL, 4'd0, 16'h7FFF, 16'h8000));
        queue_event(make_event(MODE_ENTER, 4'd0, 16'h1234, 16'hFEDC));
        queue_event(make_event(MODE_LEAVE, 4'd0, 16'hFFFF, 16'hFFFF));
        queue_event(make_event(3'd7, 4'd0, 16'h0, 16'h0));
        queue_event(make_event(MODE_RELEASE, 4'd7, 16'h0, 16'h0));
        queue_event(make_event(MODE_FRAME, 4'd0, 16'h0, 16'h0));
        clock_ms = clock_ms + 2000;
        queue_event(make_event(MODE_PRESS, 4'd0, 16'd20, 16'd20));
        for (i = 0; i < 16; i++) begin
            clock_ms = clock_ms + 5;
            queue_event(make_event(MODE_PRESS, 4'd3, 16'd0, 16'd0));   // saturates
        end
        wait_drained();

        // extremes of the registers, filter on
        write_reg(REG_SENS, 16'd255);
        write_reg(REG_FILT_EN, 16'd1);
        write_reg(REG_MIN_MOVE, 16'h7FFF);
        write_reg(REG_DRAG_THR, 16'h0000);
        write_reg(REG_DCLICK_MS, 16'hFFFF);
        queue_random_phase(60);
        wait_drained();

        // disabled: everything gives a status result
        write_reg(REG_ENABLE, 16'd0);
        queue_random_phase(20);
        wait_drained();
        write_reg(REG_ENABLE, 16'd1);
        write_reg(REG_SENS, 16'd0);
        write_reg(REG_DRAG_THR, 16'h7FFF);
        write_reg(REG_DCLICK_MS, 16'd0);
        write_reg(REG_MIN_MOVE, 16'd0);

        // sender holds off until every result is back before each transaction
        hold_sender = 1'b1;
        queue_random_phase(40);
        wait_drained();
        hold_sender = 1'b0;

        random_config();
        queue_random_phase(90);
        wait_drained();
        send_idle_pct = 52;
        recv_idle_pct = 27;
        random_config();
        queue_random_phase(90);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_config();
        queue_random_phase(80);
        wait_drained();

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### pointer_click_drag_recognizer_top.f
+incdir+rtl/core
rtl/core/pcdr_pkg.sv
rtl/core/pcdr_datapath.sv
rtl/core/pcdr_ctrl.sv
rtl/core/pointer_click_drag_recognizer_top.sv
rtl/core/pcdr_checker.sv
tb/tb_top.sv
